// ----- sv/mwuf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the maze wall union-find unit.
// No dependencies.
package mwuf_pkg;

    localparam int MAX_GRID_DEF = 16;
    localparam int WALL_W       = 10;
    localparam int GRID_W       = 5;
    localparam logic [GRID_W-1:0] GRID_RESET = 5'd8;
    localparam logic [2:0] REG_GRID_ADDR = 3'd0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_DIV,
        S_ADDR,
        S_JOIN1,
        S_JOIN2,
        S_RESTART
    } t_state;

    typedef enum logic [2:0] {
        F_PRE0,
        F_PRE1,
        F_C1,
        F_C2,
        F_POST0,
        F_POST1
    } t_step;

endpackage

// ----- sv/mwuf_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module mwuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/mwuf_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for wall index by row pitch.
// Depends on mwuf_pkg.
module mwuf_div #(
    parameter int DW = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mwuf_pkg::WALL_W-1:0] i_dividend,
    input  logic [DW-1:0]               i_divisor,
    output logic                        o_done,
    output logic [mwuf_pkg::WALL_W-1:0] o_quot,
    output logic [DW-1:0]               o_rem
);
    import mwuf_pkg::*;

    localparam int CNTW = $clog2(WALL_W + 1);

    logic [CNTW-1:0]   r_cnt;
    logic              r_done;
    logic [WALL_W-1:0] r_quo;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_div;
    logic [DW:0]       trial;
    logic              take;

    assign trial = {r_rem, r_quo[WALL_W-1]};
    assign take  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNTW'(WALL_W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - CNTW'(1);
                r_done <= (r_cnt == CNTW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[WALL_W-2:0], take};
            r_rem <= take ? DW'(trial - {1'b0, r_div}) : DW'(trial);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;
endmodule

// ----- sv/maze_wall_union_find_unit.sv -----
`timescale 1ns / 1ps
// Maze wall union-find unit: disjoint-set table in one RAM, walked one hop per cycle.
// Once complete, a start is answered in the cycle after it; else an item runs up to six finds
// (pre-check pair, both cells, post-check pair) with a divide after the pre-check pair; the
// join is skipped when the cells share a root, and a rejected wall ends after the divide.
// One item at a time; busy drops in the cycle of the result strobe. Receiver cannot stall.
// Reset (synchronous) clears the table by a sweep over all MAX_GRID*MAX_GRID cells, busy high.
// Depends on mwuf_pkg, mwuf_ram, mwuf_div.
module maze_wall_union_find_unit #(
    parameter int MAX_GRID = mwuf_pkg::MAX_GRID_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mwuf_pkg::WALL_W-1:0] i_wall_index,
    output logic                        o_strobe,
    output logic                        o_valid_wall,
    output logic                        o_removed,
    output logic                        o_complete,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mwuf_pkg::*;

    localparam int CELLS = MAX_GRID * MAX_GRID;
    localparam int CW    = $clog2(CELLS);
    localparam int EW    = $clog2(CELLS + 1) + 1;
    localparam int NW    = $clog2(MAX_GRID + 1);
    localparam int DW    = NW + 1;
    localparam int TW    = 2 * NW + 2;
    localparam int XW    = (TW > WALL_W) ? TW : WALL_W;
    localparam int PW    = WALL_W + NW;

    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic [CW-1:0]     r_cur, n_cur;
    logic [CW-1:0]     r_root_a, n_root_a, r_root_b, n_root_b, r_c2, n_c2, r_clr;
    logic [EW-1:0]     r_rank_a, n_rank_a, r_rank_b, n_rank_b;
    logic [WALL_W-1:0] r_wall;
    logic [GRID_W-1:0] r_grid;
    logic r_done, n_done, r_strobe, n_strobe, r_valid, n_valid, r_removed, n_removed;

    logic          ram_we;
    logic [CW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic          hit, same_root;
    logic          div_start, div_done;
    logic [WALL_W-1:0] div_quot;
    logic [DW-1:0]     div_rem;

    logic [NW-1:0]   side;
    logic [2*NW-1:0] nn;
    logic [CW-1:0]   last_cell;
    logic [TW-1:0]   tot;
    logic            wall_ok, col_lo;
    logic [WALL_W-1:0] mrow;
    logic [PW-1:0]   prod, c1, c2;

    mwuf_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_cur),
        .o_rdata (ram_rdata)
    );

    mwuf_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_wall),
        .i_divisor  ({side, 1'b1}),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        if (r_grid == '0) begin
            side = NW'(1);
        end else if (r_grid > MAX_GRID) begin
            side = NW'(MAX_GRID);
        end else begin
            side = NW'(r_grid);
        end
    end

    assign nn        = (2*NW)'(side) * (2*NW)'(side);
    assign last_cell = CW'(nn - (2*NW)'(1));
    assign tot       = {1'b0, nn + (2*NW)'(side), 1'b0};

    // div results: row in quotient, column in remainder
    assign wall_ok = (XW'(r_wall) >= XW'(side))
                  && (XW'(r_wall) < XW'(tot - TW'(side)))
                  && (div_rem != DW'(side))
                  && (div_rem != {side, 1'b0});
    assign col_lo  = div_rem < DW'(side);
    assign mrow    = col_lo ? div_quot - WALL_W'(1) : div_quot;
    assign prod    = PW'(mrow) * PW'(side);
    assign c1      = col_lo ? prod + PW'(div_rem)
                            : prod + PW'(div_rem) - PW'(side) - PW'(1);
    assign c2      = col_lo ? c1 + PW'(side) : c1 + PW'(1);

    assign hit       = !($signed(ram_rdata) > $signed(EW'(0)));
    assign same_root = (r_cur == r_root_a);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (r_clr == CW'(CELLS - 1)) n_state = S_IDLE;
            S_IDLE:    if (start && !r_done) n_state = S_WALK;
            S_WALK: begin
                if (hit) begin
                    case (r_step)
                        F_PRE1:  n_state = same_root ? S_IDLE : S_DIV;
                        F_C2:    n_state = same_root ? S_WALK : S_JOIN1;
                        F_POST1: n_state = S_IDLE;
                        default: n_state = S_WALK;
                    endcase
                end
            end
            S_DIV:     if (div_done) n_state = S_ADDR;
            S_ADDR:    n_state = wall_ok ? S_WALK : S_IDLE;
            S_JOIN1:   n_state = (r_rank_b == r_rank_a) ? S_JOIN2 : S_RESTART;
            S_JOIN2:   n_state = S_RESTART;
            S_RESTART: n_state = S_WALK;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_step    = r_step;
        n_cur     = r_cur;
        n_root_a  = r_root_a;
        n_root_b  = r_root_b;
        n_rank_a  = r_rank_a;
        n_rank_b  = r_rank_b;
        n_c2      = r_c2;
        n_done    = r_done;
        n_strobe  = 1'b0;
        n_valid   = r_valid;
        n_removed = r_removed;
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = '0;
        div_start = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_IDLE: begin
                if (start) begin
                    if (r_done) begin
                        n_strobe  = 1'b1;
                        n_valid   = 1'b0;
                        n_removed = 1'b0;
                    end else begin
                        n_cur  = '0;
                        n_step = F_PRE0;
                    end
                end
            end
            S_WALK: begin
                if (!hit) begin
                    n_cur = CW'(ram_rdata - EW'(1));
                end else begin
                    case (r_step)
                        F_PRE0, F_POST0: begin
                            n_root_a = r_cur;
                            n_cur    = last_cell;
                            n_step   = (r_step == F_PRE0) ? F_PRE1 : F_POST1;
                        end
                        F_PRE1: begin
                            if (same_root) begin
                                n_done    = 1'b1;
                                n_strobe  = 1'b1;
                                n_valid   = 1'b0;
                                n_removed = 1'b0;
                            end else begin
                                div_start = 1'b1;
                            end
                        end
                        F_C1: begin
                            n_root_a = r_cur;
                            n_rank_a = ram_rdata;
                            n_cur    = r_c2;
                            n_step   = F_C2;
                        end
                        F_C2: begin
                            n_root_b  = r_cur;
                            n_rank_b  = ram_rdata;
                            n_removed = !same_root;
                            if (same_root) begin
                                n_cur  = '0;
                                n_step = F_POST0;
                            end
                        end
                        default: begin
                            n_done   = same_root;
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_ADDR: begin
                n_valid = wall_ok;
                if (wall_ok) begin
                    n_cur  = CW'(c1);
                    n_c2   = CW'(c2);
                    n_step = F_C1;
                end else begin
                    n_strobe  = 1'b1;
                    n_removed = 1'b0;
                end
            end
            S_JOIN1: begin
                ram_we = 1'b1;
                if ($signed(r_rank_b) < $signed(r_rank_a)) begin
                    ram_waddr = r_root_a;
                    ram_wdata = EW'(r_root_b) + EW'(1);
                end else if (r_rank_b == r_rank_a) begin
                    ram_waddr = r_root_a;
                    ram_wdata = r_rank_a - EW'(1);
                end else begin
                    ram_waddr = r_root_b;
                    ram_wdata = EW'(r_root_a) + EW'(1);
                end
            end
            S_JOIN2: begin
                ram_we    = 1'b1;
                ram_waddr = r_root_b;
                ram_wdata = EW'(r_root_a) + EW'(1);
            end
            S_RESTART: begin
                // write of the join has landed; start the post-check walk
                n_cur  = '0;
                n_step = F_POST0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_step   <= F_PRE0;
            r_clr    <= '0;
            r_done   <= 1'b0;
            r_strobe <= 1'b0;
            r_grid   <= GRID_RESET;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_done   <= n_done;
            r_strobe <= n_strobe;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + CW'(1);
            end
            if (psel && penable && pwrite && paddr == REG_GRID_ADDR) begin
                r_grid <= pwdata[GRID_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_root_a  <= n_root_a;
        r_root_b  <= n_root_b;
        r_rank_a  <= n_rank_a;
        r_rank_b  <= n_rank_b;
        r_c2      <= n_c2;
        r_valid   <= n_valid;
        r_removed <= n_removed;
        if (r_state == S_IDLE && start) begin
            r_wall <= i_wall_index;
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_valid_wall = r_valid;
    assign o_removed    = r_removed;
    assign o_complete   = r_done;
    assign prdata       = {{(32 - GRID_W){1'b0}}, r_grid};
    assign pready       = 1'b1;

    a_removed_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_removed) |-> o_valid_wall)
        else $error("removed wall reported as invalid");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("completion flag dropped");

    a_beat_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while busy");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || r_state == S_JOIN1 || r_state == S_JOIN2))
        else $error("table written outside clear or join");

endmodule
